// File: hdl/battery_voltage_soc_gauge_defines.svh
// assertion macros for the battery gauge
// no dependencies; included by modules that carry assertions
`ifndef BATTERY_VOLTAGE_SOC_GAUGE_DEFINES_SVH
`define BATTERY_VOLTAGE_SOC_GAUGE_DEFINES_SVH

// checked outside reset
`define BVSG_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define BVSG_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/bvsg_pkg.sv
// shared types, constants and chemistry tables for the battery gauge
// no dependencies
`timescale 1ns / 1ps

package bvsg_pkg;

  localparam int VOLT_W     = 13;
  localparam int SOC_W      = 10;
  localparam int PCT_W      = 7;
  localparam int TYPE_W     = 2;
  localparam int WIN_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int IDX_W      = 5;
  localparam int FE_IDX_W   = 4;
  localparam int MUL_BITS   = 11;
  localparam int QUO_BITS   = 14;
  localparam int ITER_W     = 4;

  localparam int LI_POINTS = 21;
  localparam int FE_POINTS = 11;

  localparam logic [MUL_BITS-1:0] DIV_NUM  = 11'd1970;
  localparam logic [MUL_BITS-1:0] DIV_DEN  = 11'd1500;
  localparam logic [VOLT_W-1:0]   VOLT_MAX = 13'd8191;
  localparam logic [SOC_W-1:0]    SOC_FULL = 10'd1000;
  localparam logic [SOC_W-1:0]    SOC_TEN  = 10'd10;

  localparam logic [TYPE_W-1:0] BAT_ABSENT = 2'd0;
  localparam logic [TYPE_W-1:0] BAT_LI     = 2'd1;
  localparam logic [TYPE_W-1:0] BAT_FE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_BATTERY_TYPE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MV        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV       = 3'd4;

  localparam logic [1:0] CODE_NONE  = 2'd0;
  localparam logic [1:0] CODE_FULL  = 2'd1;
  localparam logic [1:0] CODE_LOW   = 2'd2;
  localparam logic [1:0] CODE_EMPTY = 2'd3;

  localparam logic [TYPE_W-1:0] RST_BATTERY_TYPE = BAT_ABSENT;
  localparam logic [WIN_W-1:0]  RST_WINDOW       = 7'd16;
  localparam logic [VOLT_W-1:0] RST_EMPTY_MV     = 13'd2700;
  localparam logic [VOLT_W-1:0] RST_LOW_MV       = 13'd3180;
  localparam logic [VOLT_W-1:0] RST_FULL_MV      = 13'd3300;

  localparam logic [VOLT_W-1:0] LI_MV [LI_POINTS] = '{
    13'd3270, 13'd3610, 13'd3690, 13'd3710, 13'd3730, 13'd3750, 13'd3770,
    13'd3790, 13'd3800, 13'd3820, 13'd3840, 13'd3850, 13'd3870, 13'd3910,
    13'd3950, 13'd3980, 13'd4020, 13'd4080, 13'd4110, 13'd4150, 13'd4200};
  localparam logic [PCT_W-1:0] LI_PCT [LI_POINTS] = '{
    7'd0, 7'd5, 7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45, 7'd50,
    7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85, 7'd90, 7'd95, 7'd100};
  localparam logic [VOLT_W-1:0] FE_MV [FE_POINTS] = '{
    13'd2500, 13'd3000, 13'd3130, 13'd3200, 13'd3230, 13'd3250,
    13'd3280, 13'd3300, 13'd3330, 13'd3350, 13'd3400};
  localparam logic [PCT_W-1:0] FE_PCT [FE_POINTS] = '{
    7'd0, 7'd9, 7'd14, 7'd17, 7'd20, 7'd30, 7'd40, 7'd70, 7'd90, 7'd99, 7'd100};

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  function automatic logic [VOLT_W-1:0] tbl_mv(input logic [TYPE_W-1:0] bt,
                                               input logic [IDX_W-1:0] i);
    logic [VOLT_W-1:0] r;
    r = '0;
    if (bt == BAT_FE) begin
      if (i < IDX_W'(FE_POINTS)) r = FE_MV[i[FE_IDX_W-1:0]];
    end else if (i < IDX_W'(LI_POINTS)) begin
      r = LI_MV[i];
    end
    return r;
  endfunction

  function automatic logic [PCT_W-1:0] tbl_pct(input logic [TYPE_W-1:0] bt,
                                               input logic [IDX_W-1:0] i);
    logic [PCT_W-1:0] r;
    r = '0;
    if (bt == BAT_FE) begin
      if (i < IDX_W'(FE_POINTS)) r = FE_PCT[i[FE_IDX_W-1:0]];
    end else if (i < IDX_W'(LI_POINTS)) begin
      r = LI_PCT[i];
    end
    return r;
  endfunction

  // index of the last segment start
  function automatic logic [IDX_W-1:0] tbl_last_seg(input logic [TYPE_W-1:0] bt);
    logic [IDX_W-1:0] r;
    if (bt == BAT_FE) r = IDX_W'(FE_POINTS - 2);
    else r = IDX_W'(LI_POINTS - 2);
    return r;
  endfunction

endpackage

// File: hdl/bvsg_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on bvsg_pkg
`timescale 1ns / 1ps

module bvsg_div #(
  parameter int NUM_W = 30,
  parameter int DEN_W = 18
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [NUM_W-1:0]              num,
  input  logic [DEN_W-1:0]              den,
  output logic [bvsg_pkg::VOLT_W-1:0]   quot,
  output bvsg_pkg::div_stat_t           stat
);

  localparam int SH_W = DEN_W + bvsg_pkg::QUO_BITS - 1;
  localparam int R_W  = (NUM_W > SH_W) ? NUM_W : SH_W;

  logic [R_W-1:0]                    rem;
  logic [R_W-1:0]                    dvs;
  logic [bvsg_pkg::QUO_BITS-1:0]     q;
  logic [bvsg_pkg::ITER_W-1:0]       cnt;
  logic                              busy;
  logic                              done;
  logic                              ge;

  assign ge = (rem >= dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == bvsg_pkg::ITER_W'(bvsg_pkg::QUO_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= R_W'(num);
      dvs <= R_W'(den) << (bvsg_pkg::QUO_BITS - 1);
      q   <= '0;
    end else if (busy) begin
      if (ge) rem <= rem - dvs;
      q   <= {q[bvsg_pkg::QUO_BITS-2:0], ge};
      dvs <= dvs >> 1;
    end
  end

  assign quot      = q[bvsg_pkg::VOLT_W-1:0];
  assign stat.done = done;
  assign stat.ovf  = q[bvsg_pkg::QUO_BITS-1];

endmodule

// File: hdl/battery_voltage_soc_gauge.sv
// battery gauge top level: sample averaging, divider scaling, table interpolation
// depends on bvsg_pkg, bvsg_div and battery_voltage_soc_gauge_defines.svh
// usage:
//   in channel (in_valid/in_ready, sample_mv) takes converter samples in millivolts.
//   with battery_type 0 or 3 samples are taken and dropped.
//   a sample that does not close the window is added to the sum; the block stays idle.
//   the sample that closes the window starts one reading: sum*1970/(window*1500)
//   on the shared 14-step divider, then a segment search over the chemistry table
//   (one point per cycle, up to 20), then a second divide for the interpolation.
//   the length of a reading, from that sample to the result item, is set by
//   the length of the segment search and whether the interpolation divide runs;
//   in_ready is low meanwhile.
//   out channel (out_valid/out_ready) carries voltage, charge, flags and state code
//   from an output register; further samples are taken while a result waits,
//   and a finished reading holds in its last step until the register is free.
//   cfg_we writes register cfg_index at once; write only while the block is idle.
//   reset clears the sum, the count and the output valid, and loads the
//   register defaults: no battery, window 16, empty 2700, low 3180, full 3300.
`timescale 1ns / 1ps
`include "battery_voltage_soc_gauge_defines.svh"

module battery_voltage_soc_gauge #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [SAMPLE_BITS-1:0]            sample_mv,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [bvsg_pkg::VOLT_W-1:0]       voltage_mv,
  output logic [bvsg_pkg::SOC_W-1:0]        charge_tenths,
  output logic                              full_flag,
  output logic                              low_flag,
  output logic                              empty_flag,
  output logic [1:0]                        state_code,
  input  logic                              cfg_we,
  input  logic [bvsg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bvsg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W  = SAMPLE_BITS + CNT_W;
  localparam int NUM_W  = SUM_W + bvsg_pkg::MUL_BITS;
  localparam int DEN_W  = CNT_W + bvsg_pkg::MUL_BITS;
  localparam int PROD_W = bvsg_pkg::SOC_W + bvsg_pkg::VOLT_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SCALE  = 9'b000000010,
    S_VSTART = 9'b000000100,
    S_VDIV   = 9'b000001000,
    S_SEARCH = 9'b000010000,
    S_IMUL   = 9'b000100000,
    S_ISTART = 9'b001000000,
    S_IDIV   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  // configuration registers
  logic [bvsg_pkg::TYPE_W-1:0] battery_type;
  logic [bvsg_pkg::WIN_W-1:0]  window_length;
  logic [bvsg_pkg::VOLT_W-1:0] empty_mv;
  logic [bvsg_pkg::VOLT_W-1:0] low_mv;
  logic [bvsg_pkg::VOLT_W-1:0] full_mv;

  logic [SUM_W-1:0]            sample_sum;
  logic [CNT_W-1:0]            sample_count;
  logic [CNT_W-1:0]            win_eff;
  logic [CNT_W-1:0]            count_next;
  logic [SUM_W-1:0]            sum_next;
  logic                        bat_ok;
  logic                        accept;

  logic [NUM_W-1:0]            num;
  logic [DEN_W-1:0]            den;
  logic                        div_start;
  logic [bvsg_pkg::VOLT_W-1:0] div_quot;
  bvsg_pkg::div_stat_t         div_stat;

  logic [bvsg_pkg::VOLT_W-1:0] volt;
  logic [bvsg_pkg::IDX_W-1:0]  idx;
  logic [bvsg_pkg::IDX_W-1:0]  idx_next;
  logic [bvsg_pkg::VOLT_W-1:0] seg_lo;
  logic [bvsg_pkg::VOLT_W-1:0] seg_hi;
  logic [bvsg_pkg::PCT_W-1:0]  pct_lo;
  logic [bvsg_pkg::PCT_W-1:0]  pct_hi;
  logic [bvsg_pkg::VOLT_W-1:0] lo;
  logic [bvsg_pkg::VOLT_W-1:0] span;
  logic [bvsg_pkg::SOC_W-1:0]  base;
  logic [bvsg_pkg::SOC_W-1:0]  dp;
  logic [bvsg_pkg::SOC_W-1:0]  soc;
  logic [PROD_W-1:0]           iprod;
  logic                        out_load;
  logic                        full_c;
  logic                        low_c;
  logic                        empty_c;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign bat_ok   = (battery_type == bvsg_pkg::BAT_LI) ||
                    (battery_type == bvsg_pkg::BAT_FE);

  always_comb begin
    if (window_length == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_length) > 32'(MAX_WINDOW)) begin
      win_eff = CNT_W'(MAX_WINDOW);
    end else begin
      win_eff = CNT_W'(window_length);
    end
  end

  assign count_next = sample_count + 1'b1;
  assign sum_next   = sample_sum + SUM_W'(sample_mv);

  assign seg_lo   = bvsg_pkg::tbl_mv(battery_type, idx);
  assign idx_next = idx + 1'b1;
  assign seg_hi   = bvsg_pkg::tbl_mv(battery_type, idx_next);
  assign pct_lo   = bvsg_pkg::tbl_pct(battery_type, idx);
  assign pct_hi   = bvsg_pkg::tbl_pct(battery_type, idx_next);
  assign iprod    = PROD_W'(dp) * PROD_W'(volt - lo);

  assign div_start = (state == S_VSTART) || (state == S_ISTART);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);

  assign full_c  = (volt >= full_mv);
  assign low_c   = (volt <= low_mv);
  assign empty_c = (volt <= empty_mv);

  always_ff @(posedge clk) begin
    if (rst) begin
      battery_type  <= bvsg_pkg::RST_BATTERY_TYPE;
      window_length <= bvsg_pkg::RST_WINDOW;
      empty_mv      <= bvsg_pkg::RST_EMPTY_MV;
      low_mv        <= bvsg_pkg::RST_LOW_MV;
      full_mv       <= bvsg_pkg::RST_FULL_MV;
    end else if (cfg_we) begin
      case (cfg_index)
        bvsg_pkg::REG_BATTERY_TYPE:  battery_type  <= cfg_data[bvsg_pkg::TYPE_W-1:0];
        bvsg_pkg::REG_WINDOW_LENGTH: window_length <= cfg_data[bvsg_pkg::WIN_W-1:0];
        bvsg_pkg::REG_EMPTY_MV:      empty_mv      <= cfg_data;
        bvsg_pkg::REG_LOW_MV:        low_mv        <= cfg_data;
        bvsg_pkg::REG_FULL_MV:       full_mv       <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sample_sum   <= '0;
      sample_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept && bat_ok) begin
            sample_sum <= sum_next;
            if (count_next >= win_eff) begin
              state <= S_SCALE;
            end else begin
              sample_count <= count_next;
            end
          end
        end
        S_SCALE: begin
          sample_sum   <= '0;
          sample_count <= '0;
          state        <= S_VSTART;
        end
        S_VSTART: state <= S_VDIV;
        S_VDIV: begin
          if (div_stat.done) state <= S_SEARCH;
        end
        S_SEARCH: begin
          if (idx == '0 && volt < seg_lo) begin
            state <= S_OUT;
          end else if (volt >= seg_lo && volt <= seg_hi) begin
            state <= S_IMUL;
          end else if (idx == bvsg_pkg::tbl_last_seg(battery_type)) begin
            state <= S_OUT;
          end
        end
        S_IMUL:   state <= S_ISTART;
        S_ISTART: state <= S_IDIV;
        S_IDIV: begin
          if (div_stat.done) state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_SCALE: begin
        num <= NUM_W'(sample_sum) * NUM_W'(bvsg_pkg::DIV_NUM);
        den <= DEN_W'(win_eff) * DEN_W'(bvsg_pkg::DIV_DEN);
      end
      S_VDIV: begin
        if (div_stat.done) begin
          volt <= div_stat.ovf ? bvsg_pkg::VOLT_MAX : div_quot;
          idx  <= '0;
        end
      end
      S_SEARCH: begin
        if (idx == '0 && volt < seg_lo) begin
          soc <= '0;
        end else if (volt >= seg_lo && volt <= seg_hi) begin
          lo   <= seg_lo;
          span <= seg_hi - seg_lo;
          base <= bvsg_pkg::SOC_W'(pct_lo) * bvsg_pkg::SOC_TEN;
          dp   <= bvsg_pkg::SOC_W'(pct_hi - pct_lo) * bvsg_pkg::SOC_TEN;
        end else if (idx == bvsg_pkg::tbl_last_seg(battery_type)) begin
          soc <= bvsg_pkg::SOC_FULL;
        end else begin
          idx <= idx_next;
        end
      end
      S_IMUL: begin
        num <= NUM_W'(iprod);
        den <= DEN_W'(span);
      end
      S_IDIV: begin
        if (div_stat.done) soc <= base + div_quot[bvsg_pkg::SOC_W-1:0];
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      voltage_mv    <= volt;
      charge_tenths <= soc;
      full_flag     <= full_c;
      low_flag      <= low_c;
      empty_flag    <= empty_c;
      if (full_c) state_code <= bvsg_pkg::CODE_FULL;
      else if (low_c) state_code <= bvsg_pkg::CODE_LOW;
      else if (empty_c) state_code <= bvsg_pkg::CODE_EMPTY;
      else state_code <= bvsg_pkg::CODE_NONE;
    end
  end

  bvsg_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  `BVSG_ASSERT_ALWAYS(a_reset_idle, rst |=> state == S_IDLE && !out_valid, "reset left block busy")
  `BVSG_ASSERT(a_div_done_wait, div_stat.done |-> state == S_VDIV || state == S_IDIV, "divider done while not waiting")
  `BVSG_ASSERT(a_vdiv_to_search, state == S_VDIV && div_stat.done |=> state == S_SEARCH, "voltage divide did not start search")
  `BVSG_ASSERT(a_soc_range, out_valid |-> charge_tenths <= bvsg_pkg::SOC_FULL, "charge above full scale")
  `BVSG_ASSERT(a_code_full, out_valid |-> (state_code == bvsg_pkg::CODE_FULL) == full_flag, "state code disagrees with full flag")

endmodule
